// File: design/are_pkg.sv
// Shared constants, types and codes for the axis-aligned run extractor.
package are_pkg;

    // Parameter defaults
    localparam int unsigned MAX_WIDTH_DEF        = 4096;
    localparam int unsigned MAX_HEIGHT_DEF       = 4096;
    localparam int unsigned MIN_LENGTH_FLOOR_DEF = 8;

    // Field widths
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CFG_W     = 13;  // geometry / min length registers
    localparam int unsigned GAPCFG_W  = 8;   // max_gap register
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned POS_W     = 13;  // internal coordinate, bounded by CFG_W
    localparam int unsigned OPOS_W    = 12;  // coordinate on the result port
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned GAP_W     = 9;   // gap counter, saturates
    localparam int unsigned DIM_W     = 17;  // clamped dimension, holds up to 131071

    localparam logic [GAP_W-1:0] GAP_SAT = '1;

    // Register reset values
    localparam logic [CFG_W-1:0]    RST_WIDTH   = 13'd640;
    localparam logic [CFG_W-1:0]    RST_HEIGHT  = 13'd480;
    localparam logic [CFG_W-1:0]    RST_MIN_LEN = 13'd8;
    localparam logic [GAPCFG_W-1:0] RST_MAX_GAP = 8'd0;

    // Queue depths (powers of two)
    localparam int unsigned ITEM_Q_DEPTH = 4;
    localparam int unsigned OUT_Q_DEPTH  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_MIN_LEN = 2'd2,
        CFG_MAX_GAP = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ORIENT_ROW = 1'b0,
        ORIENT_COL = 1'b1
    } t_orient;

    typedef struct packed {
        logic [CFG_W-1:0]    width;
        logic [CFG_W-1:0]    height;
        logic [CFG_W-1:0]    min_len;
        logic [GAPCFG_W-1:0] max_gap;
        logic                restart;   // geometry written: frame restarts
    } t_cfg;

    typedef struct packed {
        logic             on;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             row_end;
        logic             frame_end;
    } t_item;

    typedef struct packed {
        logic             active;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
        logic [GAP_W-1:0] gap;
    } t_run;

    typedef struct packed {
        logic              orientation;
        logic [OPOS_W-1:0] line_position;
        logic [OPOS_W-1:0] run_first;
        logic [OPOS_W-1:0] run_last;
        logic [LEN_W-1:0]  run_length;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;   // results pushed this cycle, 0..2
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// File: design/are_front.sv
// Front end: pixel intake, raster position tracking and line-end classification.
module are_front #(
    parameter int unsigned MAX_WIDTH  = are_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = are_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  are_pkg::t_cfg             i_cfg,
    input  logic                      i_clearing,
    input  logic                      i_pixel_valid,
    output logic                      o_pixel_ready,
    input  logic [are_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output are_pkg::t_item            o_q_item
);

    logic [are_pkg::POS_W-1:0] r_x, n_x;
    logic [are_pkg::POS_W-1:0] r_y, n_y;
    logic [are_pkg::DIM_W-1:0] w_eff, h_eff;
    logic                      row_end, frame_end, accept;

    function automatic logic [are_pkg::DIM_W-1:0] clamp_dim(
        input logic [are_pkg::CFG_W-1:0] v,
        input logic [are_pkg::DIM_W-1:0] lim
    );
        logic [are_pkg::DIM_W-1:0] ve;
        ve = are_pkg::DIM_W'(v);
        if (v == '0) begin
            return are_pkg::DIM_W'(1);
        end else if (ve > lim) begin
            return lim;
        end
        return ve;
    endfunction

    assign w_eff = clamp_dim(i_cfg.width,  are_pkg::DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(i_cfg.height, are_pkg::DIM_W'(MAX_HEIGHT));

    assign row_end   = (are_pkg::DIM_W'(r_x) + are_pkg::DIM_W'(1)) >= w_eff;
    assign frame_end = (are_pkg::DIM_W'(r_y) + are_pkg::DIM_W'(1)) >= h_eff;

    assign o_pixel_ready = !i_q_full && !i_clearing;
    assign accept        = i_pixel_valid && o_pixel_ready;

    assign o_q_push           = accept;
    assign o_q_item.on        = |i_pixel;
    assign o_q_item.x         = r_x;
    assign o_q_item.y         = r_y;
    assign o_q_item.row_end   = row_end;
    assign o_q_item.frame_end = frame_end;

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (accept) begin
            if (row_end) begin
                n_x = '0;
                n_y = frame_end ? '0 : r_y + are_pkg::POS_W'(1);
            end else begin
                n_x = r_x + are_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

endmodule

// File: design/are_queue.sv
// Short item queue between the front end and the run engine.
module are_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  are_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output are_pkg::t_item o_item
);

    localparam int unsigned DEPTH = are_pkg::ITEM_Q_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    are_pkg::t_item  r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

// File: design/are_back.sv
// Run engine: row run register, column run memory, closing and length filter.
module are_back #(
    parameter int unsigned MAX_WIDTH        = are_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MIN_LENGTH_FLOOR = are_pkg::MIN_LENGTH_FLOOR_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  are_pkg::t_cfg  i_cfg,
    output logic           o_clearing,
    input  logic           i_q_valid,
    input  are_pkg::t_item i_q_item,
    output logic           o_q_pop,
    input  logic           i_room,
    output are_pkg::t_push o_push
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned LW = are_pkg::POS_W + 1;

    typedef struct packed {
        are_pkg::t_run run;
        logic          close;
    } t_step;

    are_pkg::t_run  r_col_mem [MAX_WIDTH];
    are_pkg::t_run  r_rd_run;
    are_pkg::t_run  r_fwd_run;
    logic           r_fwd;
    are_pkg::t_run  r_row;
    are_pkg::t_item r_item;
    logic           r_b_valid;
    logic           r_clearing;
    logic [AW-1:0]  r_clr_addr;

    are_pkg::t_run  col_cur;
    t_step          row_step, col_step;
    logic           b_fire, b_load;
    logic           row_emit, col_emit;
    logic [LW-1:0]  min_len;
    are_pkg::t_result row_res, col_res;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    are_pkg::t_run  mem_wd;

    function automatic t_step advance(
        input are_pkg::t_run                 r,
        input logic [are_pkg::POS_W-1:0]     pos,
        input logic                          on,
        input logic                          line_end,
        input logic [are_pkg::GAPCFG_W-1:0]  max_gap
    );
        t_step s;
        s.run   = r;
        s.close = 1'b0;
        if (on) begin
            if (!r.active) begin
                s.run.active = 1'b1;
                s.run.first  = pos;
            end
            s.run.last = pos;
            s.run.gap  = '0;
        end else if (r.active) begin
            if (r.gap != are_pkg::GAP_SAT) begin
                s.run.gap = r.gap + are_pkg::GAP_W'(1);
            end
            if (s.run.gap > are_pkg::GAP_W'(max_gap)) begin
                s.close = 1'b1;
            end
        end
        if (line_end && s.run.active) begin
            s.close = 1'b1;
        end
        if (s.close) begin
            s.run.active = 1'b0;
            s.run.gap    = '0;
        end
        return s;
    endfunction

    function automatic logic [LW-1:0] run_len(input are_pkg::t_run r);
        return LW'(r.last) - LW'(r.first) + LW'(1);
    endfunction

    // Long-enough closed run?
    function automatic logic keep(input t_step s, input logic [LW-1:0] min_l);
        return s.close && (s.run.last >= s.run.first) && (run_len(s.run) >= min_l);
    endfunction

    function automatic are_pkg::t_result make_res(
        input are_pkg::t_run             r,
        input are_pkg::t_orient          orient,
        input logic [are_pkg::POS_W-1:0] line
    );
        are_pkg::t_result o;
        o.orientation   = orient;
        o.line_position = line[are_pkg::OPOS_W-1:0];
        o.run_first     = r.first[are_pkg::OPOS_W-1:0];
        o.run_last      = r.last[are_pkg::OPOS_W-1:0];
        o.run_length    = are_pkg::LEN_W'(run_len(r));
        o.last_result   = 1'b0;
        return o;
    endfunction

    assign min_len = (i_cfg.min_len < are_pkg::CFG_W'(MIN_LENGTH_FLOOR))
                     ? LW'(MIN_LENGTH_FLOOR) : LW'(i_cfg.min_len);

    assign col_cur  = r_fwd ? r_fwd_run : r_rd_run;
    assign row_step = advance(r_row, r_item.x, r_item.on, r_item.row_end, i_cfg.max_gap);
    assign col_step = advance(col_cur, r_item.y, r_item.on, r_item.frame_end, i_cfg.max_gap);

    assign b_fire  = r_b_valid && i_room;
    assign b_load  = i_q_valid && (!r_b_valid || b_fire);
    assign o_q_pop = b_load;

    assign row_emit = b_fire && keep(row_step, min_len);
    assign col_emit = b_fire && keep(col_step, min_len);
    assign row_res  = make_res(row_step.run, are_pkg::ORIENT_ROW, r_item.y);
    assign col_res  = make_res(col_step.run, are_pkg::ORIENT_COL, r_item.x);

    // Horizontal result goes first; last_result marks the final one.
    always_comb begin
        o_push.cnt = 2'(row_emit) + 2'(col_emit);
        o_push.r0  = row_emit ? row_res : col_res;
        o_push.r1  = col_res;
        o_push.r0.last_result = (o_push.cnt == 2'd1);
        o_push.r1.last_result = 1'b1;
    end

    assign o_clearing = r_clearing;

    assign mem_we = r_clearing || b_fire;
    assign mem_wa = r_clearing ? r_clr_addr : AW'(r_item.x);
    assign mem_wd = r_clearing ? '0 : col_step.run;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_col_mem[mem_wa] <= mem_wd;
        end
        if (b_load) begin
            r_rd_run <= r_col_mem[AW'(i_q_item.x)];
        end
    end

    // Same-column bypass (single-column frames)
    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_fwd     <= b_fire && (r_item.x == i_q_item.x);
            r_fwd_run <= col_step.run;
            r_item    <= i_q_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_row <= '0;
        end else if (b_fire) begin
            r_row <= row_step.run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

endmodule

// File: design/are_out_buf.sv
// Result buffer: takes up to two results a cycle, hands out one per beat.
module are_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  are_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output are_pkg::t_result o_data
);

    localparam int unsigned DEPTH = are_pkg::OUT_Q_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    are_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wptr + PW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PW'(i_push.cnt);
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
        end
    end

endmodule

// File: design/axis_aligned_run_extractor.sv
// Top level of the axis-aligned run extractor: config registers and channel wiring.
//
//  channel   direction  handshake                        payload
//  pixel     in         i_pixel_valid / o_pixel_ready    i_pixel
//  run       out        o_run_valid / i_run_ready        o_orientation .. o_last_result
//  config    in         i_cfg_wr_en (no wait)            i_cfg_idx, i_cfg_data
//
//  One pixel beat per cycle sustained unless clearing or result back-pressure
//  holds o_pixel_ready low. o_run_valid rises once a pixel's results have passed
//  the queue, column memory read and run update, and the results drain one per beat.
//  Reset, and any write of image_width or image_height, starts a clearing pass
//  over all MAX_WIDTH entries of the column run memory, with o_pixel_ready low.
//  Reset is synchronous, active low. Result back-pressure: the 4-deep result buffer
//  stops taking runs once it holds three, the run stage keeps one pixel, then the
//  4-deep pixel queue fills and o_pixel_ready drops.
module axis_aligned_run_extractor #(
    parameter int unsigned MAX_WIDTH        = are_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT       = are_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned MIN_LENGTH_FLOOR = are_pkg::MIN_LENGTH_FLOOR_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_cfg_wr_en,
    input  logic [are_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [are_pkg::CFG_W-1:0]     i_cfg_data,
    // pixels
    input  logic                          i_pixel_valid,
    output logic                          o_pixel_ready,
    input  logic [are_pkg::PIX_W-1:0]     i_pixel,
    // runs
    output logic                          o_run_valid,
    input  logic                          i_run_ready,
    output logic                          o_orientation,
    output logic [are_pkg::OPOS_W-1:0]    o_line_position,
    output logic [are_pkg::OPOS_W-1:0]    o_run_first,
    output logic [are_pkg::OPOS_W-1:0]    o_run_last,
    output logic [are_pkg::LEN_W-1:0]     o_run_length,
    output logic                          o_last_result
);

    logic [are_pkg::CFG_W-1:0]    r_width, r_height, r_min_len;
    logic [are_pkg::GAPCFG_W-1:0] r_max_gap;
    are_pkg::t_cfg                cfg;
    are_pkg::t_cfg_idx            cfg_idx;

    logic             clearing;
    logic             q_full, q_push, q_valid, q_pop;
    are_pkg::t_item   q_in, q_out;
    are_pkg::t_push   push;
    logic             room;
    are_pkg::t_result res;

    assign cfg_idx = are_pkg::t_cfg_idx'(i_cfg_idx);

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= are_pkg::RST_WIDTH;
            r_height  <= are_pkg::RST_HEIGHT;
            r_min_len <= are_pkg::RST_MIN_LEN;
            r_max_gap <= are_pkg::RST_MAX_GAP;
        end else if (i_cfg_wr_en) begin
            case (cfg_idx)
                are_pkg::CFG_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                are_pkg::CFG_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                are_pkg::CFG_MIN_LEN: begin
                    r_min_len <= i_cfg_data;
                end
                are_pkg::CFG_MAX_GAP: begin
                    r_max_gap <= i_cfg_data[are_pkg::GAPCFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Geometry write restarts the frame: position, row run, column memory.
    assign cfg.width   = r_width;
    assign cfg.height  = r_height;
    assign cfg.min_len = r_min_len;
    assign cfg.max_gap = r_max_gap;
    assign cfg.restart = i_cfg_wr_en &&
                         (cfg_idx inside {are_pkg::CFG_WIDTH, are_pkg::CFG_HEIGHT});

    are_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_clearing    (clearing),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    are_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    are_back #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MIN_LENGTH_FLOOR (MIN_LENGTH_FLOOR)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .o_clearing (clearing),
        .i_q_valid  (q_valid),
        .i_q_item   (q_out),
        .o_q_pop    (q_pop),
        .i_room     (room),
        .o_push     (push)
    );

    are_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_run_valid),
        .i_ready (i_run_ready),
        .o_data  (res)
    );

    assign o_orientation   = res.orientation;
    assign o_line_position = res.line_position;
    assign o_run_first     = res.run_first;
    assign o_run_last      = res.run_last;
    assign o_run_length    = res.run_length;
    assign o_last_result   = res.last_result;

endmodule

// File: design/are_checker.sv
// Port-level checks for the run extractor, bound to the top level.
module are_checker #(
    parameter int unsigned MIN_LENGTH_FLOOR = are_pkg::MIN_LENGTH_FLOOR_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr_en,
    input logic [are_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic                          o_pixel_ready,
    input logic                          o_run_valid,
    input logic                          i_run_ready,
    input logic                          o_orientation,
    input logic [are_pkg::OPOS_W-1:0]    o_line_position,
    input logic [are_pkg::OPOS_W-1:0]    o_run_first,
    input logic [are_pkg::OPOS_W-1:0]    o_run_last,
    input logic [are_pkg::LEN_W-1:0]     o_run_length,
    input logic                          o_last_result
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_valid && !i_run_ready |=> o_run_valid && $stable(o_run_first) &&
        $stable(o_run_last) && $stable(o_run_length) && $stable(o_line_position) &&
        $stable(o_orientation) && $stable(o_last_result))
        else $error("run beat changed while stalled");

    // Length agrees with endpoints
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_valid |->
        o_run_length[are_pkg::OPOS_W-1:0] ==
        are_pkg::OPOS_W'(o_run_last - o_run_first + are_pkg::OPOS_W'(1)))
        else $error("run length does not match first/last");

    // Short runs are filtered
    a_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_valid |-> o_run_length >= are_pkg::LEN_W'(MIN_LENGTH_FLOOR))
        else $error("run shorter than floor emitted");

    // Memory clear follows reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pixel_ready)
        else $error("pixel ready right after reset");

    // Geometry write starts a clear
    a_geom_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && (i_cfg_idx == are_pkg::CFG_WIDTH || i_cfg_idx == are_pkg::CFG_HEIGHT)
        |=> !o_pixel_ready)
        else $error("pixel ready right after geometry write");

endmodule

bind axis_aligned_run_extractor are_checker #(
    .MIN_LENGTH_FLOOR (MIN_LENGTH_FLOOR)
) u_are_checker (.*);
